// File: hw/rtl/carp_pkg.sv
// shared types and constants of the cascaded angle/rate controller
`default_nettype none

package carp_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // register widths
  localparam int GAIN_W  = 32;
  localparam int LIMIT_W = 15;

  // result and state widths
  localparam int DRIVE_W = 16;
  localparam int ESUM_W  = 17;

  // Q.F datapath: magnitudes saturate at 2^60, signed sums need one more bit
  localparam int MAG_W = 61;
  localparam int ACC_W = MAG_W + 1;
  localparam logic [MAG_W-1:0] CAP_Q = {1'b1, {(MAG_W-1){1'b0}}};

  // multiplier digit size
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = GAIN_W / DIGIT_W;

  // register reset values
  localparam logic signed [GAIN_W-1:0] OUTER_KP_RST   = 32'sd8519680;
  localparam logic signed [GAIN_W-1:0] OUTER_KI_RST   = 32'sd6554;
  localparam logic signed [GAIN_W-1:0] OUTER_KD_RST   = 32'sd18350080;
  localparam logic signed [GAIN_W-1:0] INNER_KP_RST   = 32'sd851968;
  localparam logic signed [GAIN_W-1:0] INNER_KD_RST   = -32'sd5242880;
  localparam logic signed [GAIN_W-1:0] GYRO_SCALE_RST = 32'sd294912;
  localparam logic [LIMIT_W-1:0]       INT_LIMIT_RST  = 15'd1000;
  localparam logic [LIMIT_W-1:0]       OUT_LIMIT_RST  = 15'd28000;

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OUTER_KP       = 3'd0,
    REG_OUTER_KI       = 3'd1,
    REG_OUTER_KD       = 3'd2,
    REG_INNER_KP       = 3'd3,
    REG_INNER_KD       = 3'd4,
    REG_GYRO_SCALE     = 3'd5,
    REG_INTEGRAL_LIMIT = 3'd6,
    REG_OUTPUT_LIMIT   = 3'd7
  } cfg_index_t;

  // controller sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_FINAL
  } ctrl_state_t;

  // product order through the shared multiplier
  typedef enum logic [2:0] {
    STEP_KP,
    STEP_KI,
    STEP_KD,
    STEP_GYRO,
    STEP_INNER_KP,
    STEP_INNER_KD
  } prod_step_t;

  // multiplier control and status
  typedef struct packed {
    logic start;
    logic frac;
    logic neg;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/carp_if.sv
// request and result channel interfaces of the controller
`default_nettype none

interface carp_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] target_angle;
  logic signed [SAMPLE_WIDTH-1:0] measured_angle;
  logic signed [SAMPLE_WIDTH-1:0] gyro_rate;

  modport source (
    output valid, target_angle, measured_angle, gyro_rate,
    input  ready
  );

  modport sink (
    input  valid, target_angle, measured_angle, gyro_rate,
    output ready
  );
endinterface

interface carp_result_if
  import carp_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive;
  logic                      saturated;

  modport source (
    output valid, drive, saturated,
    input  ready
  );

  modport sink (
    input  valid, drive, saturated,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/carp_mul.sv
// digit-serial saturating multiplier: magnitude times gain, 4 gain bits per cycle
`default_nettype none

module carp_mul
  import carp_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mul_req_t                 req,
  input  wire logic [MAG_W-1:0]         a_mag,
  input  wire logic [GAIN_W-1:0]        g_mag,
  output mul_rsp_t                      rsp,
  output logic signed [ACC_W-1:0]       product
);

  localparam int PROD_W = MAG_W + GAIN_FRAC_BITS + DIGIT_W + 1;
  localparam int CNT_W  = $clog2(NUM_DIGITS + 1);
  // smallest full product whose scaled value passes the cap
  localparam logic [PROD_W-1:0] LIM_INT  = PROD_W'(CAP_Q) + PROD_W'(1);
  localparam logic [PROD_W-1:0] LIM_FRAC = LIM_INT << GAIN_FRAC_BITS;

  logic [MAG_W-1:0]         a_reg;
  logic [GAIN_W-1:0]        g_sr;
  logic [PROD_W-1:0]        prod;
  logic                     ovf;
  logic                     neg;
  logic                     frac;
  logic [CNT_W-1:0]         cnt;
  logic                     busy;
  logic                     done;

  logic [DIGIT_W-1:0]       digit;
  logic [MAG_W+DIGIT_W-1:0] pp;
  logic [PROD_W-1:0]        prod_next;
  logic                     over;
  logic [PROD_W-1:0]        scaled;
  logic [MAG_W-1:0]         res_mag;
  logic signed [ACC_W-1:0]  res_signed;
  logic                     last_digit;

  // one digit of the gain per cycle, most significant first
  assign digit      = g_sr[GAIN_W-1 -: DIGIT_W];
  assign pp         = {{DIGIT_W{1'b0}}, a_reg} * {{MAG_W{1'b0}}, digit};
  assign prod_next  = (prod << DIGIT_W) + PROD_W'(pp);
  assign over       = prod_next >= (frac ? LIM_FRAC : LIM_INT);
  assign last_digit = cnt == CNT_W'(NUM_DIGITS);

  // truncate toward zero, cap and apply sign
  assign scaled     = frac ? (prod >> GAIN_FRAC_BITS) : prod;
  assign res_mag    = ovf ? CAP_Q : scaled[MAG_W-1:0];
  assign res_signed = neg ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (last_digit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_reg <= a_mag;
      g_sr  <= g_mag;
      prod  <= '0;
      ovf   <= 1'b0;
      neg   <= req.neg;
      frac  <= req.frac;
    end else if (busy && !last_digit) begin
      g_sr <= g_sr << DIGIT_W;
      prod <= prod_next;
      ovf  <= ovf | over;
    end else if (busy) begin
      product <= res_signed;
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;

endmodule

`default_nettype wire

// File: hw/rtl/cascaded_angle_rate_pid.sv
// cascaded angle/rate controller for one gimbal axis, top level
//
//   port       dir   kind          content
//   sample     in    valid/ready   target_angle, measured_angle, gyro_rate
//   result     out   valid/ready   drive, saturated
//   cfg_*      in    write only    gain and limit registers
//
// Each request runs six products through one shared multiplier that consumes 4 gain bits
// per cycle (per product a load step, then the gain digits in turn, a result step and a
// done step), then clamps the output in the final state. A new request is taken as soon
// as the sequencer is idle, even while the previous result still waits in the output
// register, so a request is taken only after the previous one has been loaded into that
// register; the final clamp stalls while an untaken result holds the output register.
// Reset clears the registers to their defaults and the integral and history state to zero.
`default_nettype none

module cascaded_angle_rate_pid
  import carp_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  carp_sample_if.sink                 sample,
  carp_result_if.source               result
);

  localparam int DIFF_W = SAMPLE_WIDTH + 1;
  localparam int SUM_W  = ((DIFF_W > ESUM_W) ? DIFF_W : ESUM_W) + 1;
  localparam logic signed [ACC_W:0] CAP_POS = $signed((ACC_W + 1)'(CAP_Q));
  localparam logic signed [ACC_W:0] CAP_NEG = -CAP_POS;

  // configuration registers
  logic signed [GAIN_W-1:0] outer_kp;
  logic signed [GAIN_W-1:0] outer_ki;
  logic signed [GAIN_W-1:0] outer_kd;
  logic signed [GAIN_W-1:0] inner_kp;
  logic signed [GAIN_W-1:0] inner_kd;
  logic signed [GAIN_W-1:0] gyro_scale;
  logic [LIMIT_W-1:0]       integral_limit;
  logic [LIMIT_W-1:0]       output_limit;

  // loop state
  logic signed [ESUM_W-1:0]       error_sum;
  logic signed [SAMPLE_WIDTH-1:0] last_angle;
  logic signed [SAMPLE_WIDTH-1:0] last_rate;

  // per request operands
  logic signed [DIFF_W-1:0]       err;
  logic signed [DIFF_W-1:0]       dang;
  logic signed [DIFF_W-1:0]       drate;
  logic signed [SAMPLE_WIDTH-1:0] rate;
  logic signed [ACC_W-1:0]        acc;

  // sequencer
  ctrl_state_t state;
  ctrl_state_t state_next;
  prod_step_t  step;

  // output register
  logic                      out_valid;
  logic signed [DRIVE_W-1:0] out_drive;
  logic                      out_saturated;

  logic                      accept;
  logic                      out_load;
  logic signed [DIFF_W-1:0]  err_now;
  logic signed [DIFF_W-1:0]  dang_now;
  logic signed [DIFF_W-1:0]  drate_now;
  logic signed [SUM_W-1:0]   esum_raw;
  logic signed [SUM_W-1:0]   ilim_pos;
  logic signed [SUM_W-1:0]   ilim_neg;
  logic signed [ESUM_W-1:0]  error_sum_next;

  logic signed [ACC_W-1:0]   op;
  logic signed [ACC_W-1:0]   op_neg;
  logic signed [GAIN_W-1:0]  gain;
  logic signed [GAIN_W-1:0]  gain_neg;
  logic [MAG_W-1:0]          op_mag;
  logic [GAIN_W-1:0]         gain_mag;

  mul_req_t                  mul_req;
  mul_rsp_t                  mul_rsp;
  logic signed [ACC_W-1:0]   product;

  logic signed [ACC_W:0]     acc_base;
  logic signed [ACC_W:0]     acc_sum;
  logic signed [ACC_W-1:0]   acc_next;

  logic signed [ACC_W-1:0]   lim_pos;
  logic signed [ACC_W-1:0]   lim_neg;
  logic [ACC_W-1:0]          acc_abs;
  logic [ACC_W-1:0]          acc_shift;
  logic [DRIVE_W-1:0]        trunc;
  logic signed [DRIVE_W-1:0] drive_val;
  logic                      sat_val;

  assign accept   = sample.valid && sample.ready;
  assign out_load = (state == ST_FINAL) && (!out_valid || result.ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_kp       <= OUTER_KP_RST;
      outer_ki       <= OUTER_KI_RST;
      outer_kd       <= OUTER_KD_RST;
      inner_kp       <= INNER_KP_RST;
      inner_kd       <= INNER_KD_RST;
      gyro_scale     <= GYRO_SCALE_RST;
      integral_limit <= INT_LIMIT_RST;
      output_limit   <= OUT_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        REG_OUTER_KP:       outer_kp       <= $signed(cfg_data[GAIN_W-1:0]);
        REG_OUTER_KI:       outer_ki       <= $signed(cfg_data[GAIN_W-1:0]);
        REG_OUTER_KD:       outer_kd       <= $signed(cfg_data[GAIN_W-1:0]);
        REG_INNER_KP:       inner_kp       <= $signed(cfg_data[GAIN_W-1:0]);
        REG_INNER_KD:       inner_kd       <= $signed(cfg_data[GAIN_W-1:0]);
        REG_GYRO_SCALE:     gyro_scale     <= $signed(cfg_data[GAIN_W-1:0]);
        REG_INTEGRAL_LIMIT: integral_limit <= cfg_data[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:   output_limit   <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  // error, differences and clamped integral of the incoming request
  always_comb begin
    err_now   = DIFF_W'(sample.measured_angle) - DIFF_W'(sample.target_angle);
    dang_now  = DIFF_W'(sample.measured_angle) - DIFF_W'(last_angle);
    drate_now = DIFF_W'(sample.gyro_rate) - DIFF_W'(last_rate);
    esum_raw  = SUM_W'(error_sum) + SUM_W'(err_now);
    ilim_pos  = $signed(SUM_W'(integral_limit));
    ilim_neg  = -ilim_pos;
    priority if (esum_raw > ilim_pos) begin
      error_sum_next = ESUM_W'(ilim_pos);
    end else if (esum_raw < ilim_neg) begin
      error_sum_next = ESUM_W'(ilim_neg);
    end else begin
      error_sum_next = ESUM_W'(esum_raw);
    end
  end

  // loop state, updated as the request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_angle <= '0;
      last_rate  <= '0;
    end else if (accept) begin
      error_sum  <= error_sum_next;
      last_angle <= sample.measured_angle;
      last_rate  <= sample.gyro_rate;
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (accept) begin
      err   <= err_now;
      dang  <= dang_now;
      drate <= drate_now;
      rate  <= sample.gyro_rate;
    end
  end

  // operand and gain for the current product
  always_comb begin
    unique case (step)
      STEP_KP: begin
        op   = ACC_W'(err);
        gain = outer_kp;
      end
      STEP_KI: begin
        op   = ACC_W'(error_sum);
        gain = outer_ki;
      end
      STEP_KD: begin
        op   = ACC_W'(dang);
        gain = outer_kd;
      end
      STEP_GYRO: begin
        op   = ACC_W'(rate);
        gain = gyro_scale;
      end
      STEP_INNER_KP: begin
        op   = acc;
        gain = inner_kp;
      end
      STEP_INNER_KD: begin
        op   = ACC_W'(drate);
        gain = inner_kd;
      end
      default: begin
        op   = '0;
        gain = '0;
      end
    endcase
    op_neg   = -op;
    gain_neg = -gain;
    op_mag   = op[ACC_W-1] ? op_neg[MAG_W-1:0] : op[MAG_W-1:0];
    gain_mag = gain[GAIN_W-1] ? gain_neg : gain;
  end

  carp_mul #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .a_mag   (op_mag),
    .g_mag   (gain_mag),
    .rsp     (mul_rsp),
    .product (product)
  );

  // fold the product into the running sum (restart at KP, inner KP; gyro subtracts), capped
  always_comb begin
    if (step == STEP_KP || step == STEP_INNER_KP) begin
      acc_base = '0;
    end else begin
      acc_base = (ACC_W + 1)'(acc);
    end
    if (step == STEP_GYRO) begin
      acc_sum = acc_base - (ACC_W + 1)'(product);
    end else begin
      acc_sum = acc_base + (ACC_W + 1)'(product);
    end
    priority if (acc_sum > CAP_POS) begin
      acc_next = ACC_W'(CAP_POS);
    end else if (acc_sum < CAP_NEG) begin
      acc_next = ACC_W'(CAP_NEG);
    end else begin
      acc_next = ACC_W'(acc_sum);
    end
  end

  // accumulator and product step
  always_ff @(posedge clk) begin
    if (state == ST_WAIT && mul_rsp.done) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_KP;
    end else if (accept) begin
      step <= STEP_KP;
    end else if (state == ST_WAIT && mul_rsp.done && step != STEP_INNER_KD) begin
      step <= prod_step_t'(step + 3'd1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_rsp.done) begin
          state_next = (step == STEP_INNER_KD) ? ST_FINAL : ST_LOAD;
        end
      end
      ST_FINAL: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer outputs
  always_comb begin
    sample.ready  = state == ST_IDLE;
    mul_req.start = state == ST_LOAD;
    mul_req.frac  = step == STEP_INNER_KP;
    mul_req.neg   = op[ACC_W-1] ^ gain[GAIN_W-1];
  end

  // output clamp and truncation toward zero
  always_comb begin
    lim_pos   = $signed(ACC_W'(output_limit) << GAIN_FRAC_BITS);
    lim_neg   = -lim_pos;
    acc_abs   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    acc_shift = acc_abs >> GAIN_FRAC_BITS;
    trunc     = acc_shift[DRIVE_W-1:0];
    priority if (acc > lim_pos) begin
      drive_val = $signed(DRIVE_W'(output_limit));
      sat_val   = 1'b1;
    end else if (acc < lim_neg) begin
      drive_val = -$signed(DRIVE_W'(output_limit));
      sat_val   = 1'b1;
    end else begin
      drive_val = acc[ACC_W-1] ? $signed(DRIVE_W'(0) - trunc) : $signed(trunc);
      sat_val   = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_drive     <= drive_val;
      out_saturated <= sat_val;
    end
  end

  assign result.valid     = out_valid;
  assign result.drive     = out_drive;
  assign result.saturated = out_saturated;

`ifndef SYNTHESIS
  // a product starts only on an idle multiplier
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  // a finished product is only reported while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> state == ST_WAIT)
    else $error("product finished outside the wait state");

  // the running sum stays inside the saturation bound
  a_acc_capped: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINAL |-> (acc <= CAP_POS && acc >= CAP_NEG))
    else $error("accumulator beyond saturation bound");

  // a clamped result sits exactly at the output limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_saturated) |->
      (out_drive == $signed(DRIVE_W'(output_limit)) ||
       out_drive == -$signed(DRIVE_W'(output_limit))))
    else $error("saturated result not at the output limit");
`endif

endmodule

`default_nettype wire
